// ----- sv/upm_pkg.sv -----
// Shared widths, constants and payload types of the unpremultiply and sRGB encode block.
package upm_pkg;
    localparam int InWidth     = 20;
    localparam int CodeWidth   = 8;
    localparam int FracBitsDef = 16;
    localparam int CodeMax     = 255;
    localparam int SearchSteps = 8;

    typedef logic signed [InWidth-1:0] t_in;
    typedef logic [CodeWidth-1:0]      t_code;
endpackage

// ----- sv/upm_in_if.sv -----
// Input channel: one premultiplied pixel per item.
interface upm_in_if;
    import upm_pkg::*;
    logic valid;
    logic ready;
    t_in  premult_red;
    t_in  premult_green;
    t_in  premult_blue;
    t_in  coverage;
    modport source(output valid, premult_red, premult_green, premult_blue, coverage,
                   input ready);
    modport sink(input valid, premult_red, premult_green, premult_blue, coverage,
                 output ready);
endinterface

// ----- sv/upm_out_if.sv -----
// Output channel: four encoded bytes per item.
interface upm_out_if;
    import upm_pkg::*;
    logic  valid;
    logic  ready;
    t_code red_code;
    t_code green_code;
    t_code blue_code;
    t_code alpha_code;
    modport source(output valid, red_code, green_code, blue_code, alpha_code, input ready);
    modport sink(input valid, red_code, green_code, blue_code, alpha_code, output ready);
endinterface

// ----- sv/upm_lane.sv -----
// One colour lane: clamp, bit-per-stage division by alpha, staged threshold search.
module upm_lane #(
    parameter int FracBits = upm_pkg::FracBitsDef
) (
    input  logic                                  i_clk,
    input  logic [FracBits+upm_pkg::SearchSteps:0] i_adv,
    input  upm_pkg::t_in                          i_colour,
    input  logic [FracBits:0]                     i_alpha,
    output upm_pkg::t_code                        o_code
);
    import upm_pkg::*;

    localparam int AW = FracBits + 1;
    localparam int CW = (AW > InWidth) ? AW : InWidth;
    localparam logic [AW-1:0] One = AW'(1) << FracBits;

    typedef logic [AW-1:0] t_thr [256];

    // Smallest unpremultiplied value that reaches each code.
    function automatic t_thr build_thr();
        t_thr   t;
        longint one;
        longint lim;
        longint ulin;
        longint up;
        real    r;
        one  = longint'(1) << FracBits;
        lim  = (31308 * one) / 10000000;
        t[0] = '0;
        for (int k = 1; k < 256; k++) begin
            ulin = ((200 * k - 100) * one + 658919) / 658920;
            r    = (40.0 * k + 541.0) / 10761.0;
            up   = $rtoi($ceil(real'(one) * $pow(r, 2.4)));
            if (up <= lim) up = lim + 1;
            if (ulin <= lim) up = ulin;
            if (up > one) up = one + 1;
            t[k] = AW'(up);
        end
        return t;
    endfunction

    localparam t_thr Thr = build_thr();

    logic [AW-1:0]       r_rem   [FracBits+1];
    logic [FracBits-1:0] r_q     [FracBits+1];
    logic [AW-1:0]       r_alpha [FracBits+1];
    logic                r_sat   [FracBits+1];
    logic [AW-1:0]       r_u     [SearchSteps];
    t_code               r_code  [SearchSteps];

    logic [CW-1:0] c_ext;
    logic [CW-1:0] a_ext;
    assign c_ext = CW'(i_colour[InWidth-2:0]);
    assign a_ext = CW'(i_alpha);

    always_ff @(posedge i_clk) begin
        if (i_adv[0]) begin
            r_q[0]     <= '0;
            r_alpha[0] <= (i_alpha == '0) ? One : i_alpha;
            if (i_colour[InWidth-1] || i_alpha == '0 || c_ext == '0) begin
                r_rem[0] <= '0;
                r_sat[0] <= 1'b0;
            end else if (c_ext >= a_ext) begin
                r_rem[0] <= '0;
                r_sat[0] <= 1'b1;
            end else begin
                r_rem[0] <= c_ext[AW-1:0];
                r_sat[0] <= 1'b0;
            end
        end
    end

    for (genvar s = 1; s <= FracBits; s++) begin : g_div
        logic [AW:0] sh;
        logic        ge;
        logic [AW:0] diff;
        assign sh   = {r_rem[s-1], 1'b0};
        assign ge   = sh >= {1'b0, r_alpha[s-1]};
        assign diff = sh - {1'b0, r_alpha[s-1]};
        always_ff @(posedge i_clk) begin
            if (i_adv[s]) begin
                r_rem[s]   <= ge ? diff[AW-1:0] : sh[AW-1:0];
                r_q[s]     <= {r_q[s-1][FracBits-2:0], ge};
                r_alpha[s] <= r_alpha[s-1];
                r_sat[s]   <= r_sat[s-1];
            end
        end
    end

    for (genvar j = 0; j < SearchSteps; j++) begin : g_search
        logic [AW-1:0] u_in;
        t_code         code_in;
        t_code         cand;
        if (j == 0) begin : g_first
            assign u_in    = r_sat[FracBits] ? One : {1'b0, r_q[FracBits]};
            assign code_in = '0;
        end else begin : g_next
            assign u_in    = r_u[j-1];
            assign code_in = r_code[j-1];
        end
        assign cand = code_in | (t_code'(1) << (SearchSteps - 1 - j));
        always_ff @(posedge i_clk) begin
            if (i_adv[FracBits+1+j]) begin
                r_u[j]    <= u_in;
                r_code[j] <= (Thr[cand] <= u_in) ? cand : code_in;
            end
        end
    end

    assign o_code = r_code[SearchSteps-1];
endmodule

// ----- sv/unpremultiply_srgb_encode_rgba8.sv -----
// Top level: alpha clamp and rounding, three colour lanes, output merge and flow control.
//  channel | dir | payload
//  i_pix   | in  | premult_red, premult_green, premult_blue, coverage (20b signed)
//  o_pix   | out | red_code, green_code, blue_code, alpha_code (8b)
// One item enters per cycle while the output keeps taking results.
// The depth comes from the input clamp stage, one division stage per quotient bit and eight search stages.
// Each stage holds its item until the next one frees up, so bubbles close up
// and items keep entering while a result waits at the output.
// Reset clears only the stage valid bits.
module unpremultiply_srgb_encode_rgba8 #(
    parameter int FracBits = upm_pkg::FracBitsDef
) (
    input logic      i_clk,
    input logic      i_rst_n,
    upm_in_if.sink   i_pix,
    upm_out_if.source o_pix
);
    import upm_pkg::*;

    localparam int AW    = FracBits + 1;
    localparam int CW    = (AW > InWidth) ? AW : InWidth;
    localparam int Depth = 1 + FracBits + SearchSteps;
    localparam logic [AW-1:0] One = AW'(1) << FracBits;

    logic [Depth-1:0] adv;
    logic [Depth-1:0] r_vld;
    t_code            r_acode [Depth];
    logic [AW-1:0]    alpha_c;
    logic [CW-1:0]    a_ext;
    logic [AW+7:0]    a_prod;
    logic [AW+7:0]    a_round;

    assign a_ext = CW'(i_pix.coverage[InWidth-2:0]);

    always_comb begin
        if (i_pix.coverage[InWidth-1]) begin
            alpha_c = '0;
        end else if (a_ext > CW'(One)) begin
            alpha_c = One;
        end else begin
            alpha_c = a_ext[AW-1:0];
        end
    end

    assign a_prod  = (AW+8)'(alpha_c) * (AW+8)'(CodeMax);
    assign a_round = a_prod + ((AW+8)'(1) << (FracBits - 1));

    assign adv[Depth-1] = !r_vld[Depth-1] || o_pix.ready;
    for (genvar s = 0; s < Depth - 1; s++) begin : g_adv
        assign adv[s] = !r_vld[s] || adv[s+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) r_vld[0] <= i_pix.valid;
            for (int s = 1; s < Depth; s++) begin
                if (adv[s]) r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) r_acode[0] <= a_round[FracBits +: CodeWidth];
        for (int s = 1; s < Depth; s++) begin
            if (adv[s]) r_acode[s] <= r_acode[s-1];
        end
    end

    t_code red_c;
    t_code green_c;
    t_code blue_c;

    upm_lane #(.FracBits(FracBits)) u_lane_red (
        .i_clk(i_clk), .i_adv(adv), .i_colour(i_pix.premult_red),
        .i_alpha(alpha_c), .o_code(red_c)
    );
    upm_lane #(.FracBits(FracBits)) u_lane_green (
        .i_clk(i_clk), .i_adv(adv), .i_colour(i_pix.premult_green),
        .i_alpha(alpha_c), .o_code(green_c)
    );
    upm_lane #(.FracBits(FracBits)) u_lane_blue (
        .i_clk(i_clk), .i_adv(adv), .i_colour(i_pix.premult_blue),
        .i_alpha(alpha_c), .o_code(blue_c)
    );

    assign i_pix.ready      = adv[0];
    assign o_pix.valid      = r_vld[Depth-1];
    assign o_pix.red_code   = red_c;
    assign o_pix.green_code = green_c;
    assign o_pix.blue_code  = blue_c;
    assign o_pix.alpha_code = r_acode[Depth-1];
endmodule

// ----- sim/unpremultiply_srgb_encode_rgba8_tb.sv -----
// Testbench: random and directed premultiplied pixels checked against an exact sRGB predictor.
`timescale 1ns / 1ps

class srgb_pixel_board;
    typedef struct {
        upm_pkg::t_code red;
        upm_pkg::t_code green;
        upm_pkg::t_code blue;
        upm_pkg::t_code alpha;
    } t_bytes;

    localparam int FracBits = upm_pkg::FracBitsDef;
    localparam longint One = longint'(1) << FracBits;

    t_bytes pending[$];
    int     errors;
    int     matched;

    function new();
        errors  = 0;
        matched = 0;
    endfunction

    // Exact encode: the linear segment by integer division, the power
    // segment by a search over x^5 * 10761^12 >= (40k + 541)^12 * one^5.
    function automatic upm_pkg::t_code encode_unit(longint u);
        logic [319:0] lhs;
        logic [319:0] rhs;
        int           lo;
        int           hi;
        int           mid;
        longint       q;
        if (u * 10000000 <= 31308 * One) begin
            q = (2 * 255 * 1292 * u + 100 * One) / (200 * One);
            return (q > 255) ? 8'd255 : upm_pkg::t_code'(q);
        end
        lhs = 1;
        for (int i = 0; i < 5; i++) lhs = lhs * 320'(u);
        for (int i = 0; i < 12; i++) lhs = lhs * 320'(10761);
        lo = 0;
        hi = 255;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            rhs = 1;
            for (int i = 0; i < 12; i++) rhs = rhs * 320'(40 * mid + 541);
            for (int i = 0; i < 5; i++) rhs = rhs * 320'(One);
            if (lhs >= rhs) lo = mid;
            else hi = mid - 1;
        end
        return upm_pkg::t_code'(lo);
    endfunction

    function automatic upm_pkg::t_code colour_byte(upm_pkg::t_in c, longint alpha);
        longint cv;
        cv = c;
        if (alpha == 0 || cv <= 0) return 8'd0;
        if (cv >= alpha) return encode_unit(One);
        return encode_unit((cv * One) / alpha);
    endfunction

    function void note_pixel(upm_pkg::t_in r, upm_pkg::t_in g, upm_pkg::t_in b,
                             upm_pkg::t_in a);
        longint alpha;
        t_bytes e;
        alpha = a;
        if (alpha < 0) alpha = 0;
        if (alpha > One) alpha = One;
        e.red   = colour_byte(r, alpha);
        e.green = colour_byte(g, alpha);
        e.blue  = colour_byte(b, alpha);
        e.alpha = upm_pkg::t_code'((alpha * 255 + (One >> 1)) >> FracBits);
        pending.push_back(e);
    endfunction

    function void check_pixel(upm_pkg::t_code r, upm_pkg::t_code g, upm_pkg::t_code b,
                              upm_pkg::t_code a);
        t_bytes e;
        if (pending.size() == 0) begin
            $display("%0t: unexpected output item r=%0d g=%0d b=%0d a=%0d",
                     $time, r, g, b, a);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (r !== e.red) begin
            $display("%0t: red expected %0d actual %0d", $time, e.red, r);
            errors++;
        end
        if (g !== e.green) begin
            $display("%0t: green expected %0d actual %0d", $time, e.green, g);
            errors++;
        end
        if (b !== e.blue) begin
            $display("%0t: blue expected %0d actual %0d", $time, e.blue, b);
            errors++;
        end
        if (a !== e.alpha) begin
            $display("%0t: alpha expected %0d actual %0d", $time, e.alpha, a);
            errors++;
        end
        matched++;
    endfunction
endclass

module unpremultiply_srgb_encode_rgba8_tb;
    import upm_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    bit   calm_phase = 1'b0;
    int   sent = 0;
    int   zero_alpha = 0;

    upm_in_if  pix_in ();
    upm_out_if pix_out ();

    srgb_pixel_board board = new();

    unpremultiply_srgb_encode_rgba8 dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pix  (pix_in),
        .o_pix  (pix_out)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        pix_in.valid         = 1'b0;
        pix_in.premult_red   = '0;
        pix_in.premult_green = '0;
        pix_in.premult_blue  = '0;
        pix_in.coverage      = '0;
        pix_out.ready        = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (calm_phase) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_pixel(t_in r, t_in g, t_in b, t_in a);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            pix_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_in.valid         <= 1'b1;
        pix_in.premult_red   <= r;
        pix_in.premult_green <= g;
        pix_in.premult_blue  <= b;
        pix_in.coverage      <= a;
        do @(posedge i_clk); while (!pix_in.ready);
        board.note_pixel(r, g, b, a);
        sent++;
        if (a <= 0) zero_alpha++;
    endtask

    function automatic t_in any_word();
        return t_in'($urandom());
    endfunction

    // Output side: check each accepted item, then pick the next ready level.
    initial begin
        int stall_left;
        int r;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pix_out.valid && pix_out.ready)
                board.check_pixel(pix_out.red_code, pix_out.green_code,
                                  pix_out.blue_code, pix_out.alpha_code);
            if (stall_left > 0) begin
                stall_left--;
                pix_out.ready <= 1'b0;
            end else if (calm_phase) begin
                pix_out.ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 25) begin
                    stall_left = (r < 3) ? $urandom_range(10, 40) : $urandom_range(0, 2);
                    pix_out.ready <= 1'b0;
                end else begin
                    pix_out.ready <= 1'b1;
                end
            end
        end
    end

    initial begin
        t_in a;
        int  drain;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Alpha corners: zero, negative, above one, both input extremes.
        send_pixel(20'sd1000, 20'sd2000, 20'sd3000, 20'sd0);
        send_pixel(20'sd1000, 20'sd2000, 20'sd3000, -20'sd5);
        send_pixel(20'sd30000, 20'sd65536, 20'sd100, 20'sd70000);
        send_pixel(20'sd524287, -20'sd524288, 20'sd1, 20'sd524287);
        send_pixel(20'sd524287, 20'sd524287, 20'sd524287, -20'sd524288);
        send_pixel(20'sd65536, 20'sd65536, 20'sd65536, 20'sd65536);
        // Negative colour, colour equal to and above alpha.
        send_pixel(-20'sd1, 20'sd40000, 20'sd50000, 20'sd40000);
        send_pixel(-20'sd524288, 20'sd0, 20'sd524287, 20'sd1);
        // Around the end of the linear segment with alpha at one, then colours at or below smaller alphas.
        send_pixel(20'sd205, 20'sd206, 20'sd204, 20'sd65536);
        send_pixel(20'sd1, 20'sd2, 20'sd3, 20'sd65536);
        send_pixel(20'sd65535, 20'sd32768, 20'sd13107, 20'sd65536);
        send_pixel(20'sd1, 20'sd0, 20'sd1, 20'sd1);
        send_pixel(20'sd1, 20'sd2, 20'sd3, 20'sd3);
        send_pixel(20'sd127, 20'sd128, 20'sd129, 20'sd255);
        send_pixel(20'sd32767, 20'sd32768, 20'sd1, 20'sd32768);
        send_pixel(20'sd100, 20'sd200, 20'sd300, 20'sd65535);

        for (int n = 0; n < 840; n++) begin
            calm_phase = ((n / 120) % 3) == 1;
            case ($urandom_range(0, 9))
                0, 1: send_pixel(any_word(), any_word(), any_word(), any_word());
                2: begin
                    a = t_in'($urandom_range(1, 300));
                    send_pixel(t_in'($urandom_range(0, 300)), t_in'($urandom_range(0, 300)),
                               t_in'($urandom_range(0, 300)), a);
                end
                3: send_pixel(t_in'($urandom_range(0, 400)), t_in'($urandom_range(0, 400)),
                              t_in'($urandom_range(0, 400)), 20'sd65536);
                default: begin
                    a = t_in'($urandom_range(1, 65536));
                    send_pixel(t_in'($urandom_range(0, a)), t_in'($urandom_range(0, a)),
                               t_in'($urandom_range(0, a)), a);
                end
            endcase
        end
        pix_in.valid <= 1'b0;
        calm_phase = 1'b0;

        drain = 0;
        while (board.pending.size() != 0 && drain < 20000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (40) @(posedge i_clk);
        if (board.pending.size() != 0) begin
            $display("%0t: %0d expected items never arrived", $time, board.pending.size());
            board.errors++;
        end
        $display("Sent %0d pixels (%0d with alpha at or below zero), checked %0d outputs.",
                 sent, zero_alpha, board.matched);
        $display("Stimulus mixed full-range words, small alphas and colours within alpha.");
        if (board.errors == 0)
            $display("unpremultiply_srgb_encode_rgba8 verification clean");
        else
            $display("unpremultiply_srgb_encode_rgba8 verification failed");
        $finish;
    end

    initial begin
        #5ms;
        $display("unpremultiply_srgb_encode_rgba8 verification failed");
        $finish;
    end
endmodule
